// ===== sv/arc_pkg.sv =====
// Shared types and constants for the aligned region coalescer.
`default_nettype none
package arc_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int MAX_FIELDS  = 256;

  localparam int OFF_W   = 16;
  localparam int BYTES_W = 8;
  localparam int END_W   = 17;
  localparam int LEN_W   = 17;
  localparam int FLD_W   = 9;
  localparam int CNT_W   = $clog2(MAX_FIELDS + 1);

  localparam logic [OFF_W-1:0] OFF_MASK =
    (OFFSET_BITS >= OFF_W) ? {OFF_W{1'b1}} : OFF_W'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FIELDS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [OFF_W-1:0] start;
    logic [LEN_W-1:0] length;
    logic [FLD_W-1:0] fields;
    logic             last;
  } region_t;

  typedef struct packed {
    logic [1:0] n;
    region_t    first;
    region_t    second;
  } push_t;

endpackage
`default_nettype wire

// ===== sv/aligned_region_coalescer.sv =====
// Top level of the aligned region coalescer: field stream in, region stream out.
// A field's regions pass through the input register and the result queue.
// Throughput: one field transaction per cycle while the output side keeps up; the
// output queue of four regions sets this, since a field can produce two regions.
// Reset: rst is synchronous and active high; it drops any open region and
// empties the input register and the result queue.
`default_nettype none
module aligned_region_coalescer
  import arc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata, lowest bit up: field_offset[15:0], field_bytes[23:16].
  input  wire logic [23:0] s_tdata,
  // s_tlast carries final_field.
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata, lowest bit up: region_start[15:0], region_length[32:16],
  // region_fields[41:33], zero fill [47:42].
  output logic [47:0]      m_tdata,
  // m_tlast carries region_last.
  output logic             m_tlast
);

  push_t   push;
  logic    room;
  region_t head;

  // The merge stage registers each field, compares its word-aligned start
  // against the open region and pushes any closed and final regions.
  arc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_offset (s_tdata[15:0]),
    .in_bytes  (s_tdata[23:16]),
    .in_final  (s_tlast),
    .room      (room),
    .push      (push)
  );

  // The queue decouples the two sides so a waiting region does not stall input
  // unless fewer than two slots are free.
  arc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (head)
  );

  assign m_tdata = {6'd0, head.fields, head.length, head.start};
  assign m_tlast = head.last;

endmodule
`default_nettype wire

// ===== sv/arc_merge.sv =====
// Input register, open-region state and the merge decision for one field.
`default_nettype none
module arc_merge
  import arc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [OFF_W-1:0]   in_offset,
  input  wire logic [BYTES_W-1:0] in_bytes,
  input  wire logic               in_final,
  input  wire logic               room,
  output push_t                   push
);

  logic               in_vld;
  logic [OFF_W-1:0]   in_off;
  logic [BYTES_W-1:0] in_nb;
  logic               in_fin;

  logic               open_valid;
  logic [OFF_W-1:0]   open_start;
  logic [END_W-1:0]   open_end;
  logic [CNT_W-1:0]   open_count;

  logic               open_valid_next;
  logic [OFF_W-1:0]   open_start_next;
  logic [END_W-1:0]   open_end_next;
  logic [CNT_W-1:0]   open_count_next;

  logic               advance;
  logic [OFF_W-1:0]   off_m;
  logic [OFF_W-1:0]   f_start;
  logic [END_W-1:0]   end_sum;
  logic [END_W-1:0]   f_end;
  logic               joins;
  region_t            closed;
  region_t            final_r;

  assign advance  = in_vld && room;
  assign in_ready = !in_vld || room;

  assign off_m   = in_off & OFF_MASK;
  assign f_start = {off_m[OFF_W-1:2], 2'b00};
  assign end_sum = {1'b0, off_m} + END_W'(in_nb) + END_W'(3);
  assign f_end   = {end_sum[END_W-1:2], 2'b00};
  assign joins   = open_valid && ({1'b0, f_start} <= open_end);

  always_comb begin
    open_valid_next = open_valid;
    open_start_next = open_start;
    open_end_next   = open_end;
    open_count_next = open_count;
    if (joins) begin
      if (f_end > open_end) begin
        open_end_next = f_end;
      end
      if (open_count < CNT_MAX) begin
        open_count_next = open_count + CNT_W'(1);
      end
    end else begin
      open_valid_next = 1'b1;
      open_start_next = f_start;
      open_end_next   = f_end;
      open_count_next = CNT_W'(1);
    end
  end

  always_comb begin
    closed.start   = open_start;
    closed.length  = LEN_W'(open_end - {1'b0, open_start});
    closed.fields  = FLD_W'(open_count);
    closed.last    = 1'b0;
    final_r.start  = open_start_next;
    final_r.length = LEN_W'(open_end_next - {1'b0, open_start_next});
    final_r.fields = FLD_W'(open_count_next);
    final_r.last   = 1'b1;

    push.n      = 2'd0;
    push.first  = closed;
    push.second = final_r;
    if (advance) begin
      if (open_valid && !joins) begin
        push.n = in_fin ? 2'd2 : 2'd1;
      end else if (in_fin) begin
        push.n     = 2'd1;
        push.first = final_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld     <= 1'b0;
      open_valid <= 1'b0;
      open_start <= '0;
      open_end   <= '0;
      open_count <= '0;
    end else begin
      if (in_ready) begin
        in_vld <= in_valid;
      end
      if (advance) begin
        if (in_fin) begin
          open_valid <= 1'b0;
          open_start <= '0;
          open_end   <= '0;
          open_count <= '0;
        end else begin
          open_valid <= open_valid_next;
          open_start <= open_start_next;
          open_end   <= open_end_next;
          open_count <= open_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_off <= in_offset;
      in_nb  <= in_bytes;
      in_fin <= in_final;
    end
  end

endmodule
`default_nettype wire

// ===== sv/arc_out_queue.sv =====
// Small result queue that takes up to two regions a cycle and hands out one while out_ready is high.
`default_nettype none
module arc_out_queue
  import arc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output region_t    out_data
);

  region_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push.n) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

endmodule
`default_nettype wire
